FILE: rtl/chgs_pkg.sv
`timescale 1ns / 1ps
package chgs_pkg;

    localparam int COORD_W = 16;
    localparam int TAG_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;

    // one stored point: load position on top, coordinates below
    typedef struct packed {
        logic        [TAG_W-1:0]   tag;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    localparam int POINT_W = $bits(t_point);

    // orientation and distance flags from the geometry unit
    typedef struct packed {
        logic cross_pos;
        logic cross_zero;
        logic dl_zero;
        logic dr_zero;
        logic dl_lt_dr;
        logic dl_eq_dr;
    } t_cmp_res;

endpackage

FILE: rtl/chgs_ram.sv
`timescale 1ns / 1ps
module chgs_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/chgs_cmp.sv
`timescale 1ns / 1ps
module chgs_cmp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  chgs_pkg::t_point  i_o,
    input  chgs_pkg::t_point  i_a,
    input  chgs_pkg::t_point  i_b,
    output logic              o_done,
    output chgs_pkg::t_cmp_res o_res
);

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_SUM, C_FLAG} t_cstate;

    t_cstate r_state;
    logic [2:0] r_step;
    logic signed [chgs_pkg::DIFF_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [chgs_pkg::DIFF_W-1:0] w_m0, w_m1;
    logic signed [chgs_pkg::PROD_W-1:0] w_prod;
    logic signed [chgs_pkg::PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [chgs_pkg::SUM_W-1:0]  r_cross, r_dl, r_dr;

    // pick the operand pair for this step of the shared multiplier
    always_comb begin
        unique case (r_step)
            3'd0:    begin w_m0 = r_ax; w_m1 = r_by; end
            3'd1:    begin w_m0 = r_bx; w_m1 = r_ay; end
            3'd2:    begin w_m0 = r_ax; w_m1 = r_ax; end
            3'd3:    begin w_m0 = r_ay; w_m1 = r_ay; end
            3'd4:    begin w_m0 = r_bx; w_m1 = r_bx; end
            default: begin w_m0 = r_by; w_m1 = r_by; end
        endcase
    end

    assign w_prod = w_m0 * w_m1;

    // sequence differences, six products, sums, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    o_done <= 1'b0;
                    if (i_start) begin
                        r_ax    <= chgs_pkg::DIFF_W'(i_a.x) - chgs_pkg::DIFF_W'(i_o.x);
                        r_ay    <= chgs_pkg::DIFF_W'(i_a.y) - chgs_pkg::DIFF_W'(i_o.y);
                        r_bx    <= chgs_pkg::DIFF_W'(i_b.x) - chgs_pkg::DIFF_W'(i_o.x);
                        r_by    <= chgs_pkg::DIFF_W'(i_b.y) - chgs_pkg::DIFF_W'(i_o.y);
                        r_step  <= '0;
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    unique case (r_step)
                        3'd0:    r_p0 <= w_prod;
                        3'd1:    r_p1 <= w_prod;
                        3'd2:    r_p2 <= w_prod;
                        3'd3:    r_p3 <= w_prod;
                        3'd4:    r_p4 <= w_prod;
                        default: r_p5 <= w_prod;
                    endcase
                    if (r_step == 3'd5) begin
                        r_state <= C_SUM;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                C_SUM: begin
                    r_cross <= chgs_pkg::SUM_W'(r_p0) - chgs_pkg::SUM_W'(r_p1);
                    r_dl    <= chgs_pkg::SUM_W'(r_p2) + chgs_pkg::SUM_W'(r_p3);
                    r_dr    <= chgs_pkg::SUM_W'(r_p4) + chgs_pkg::SUM_W'(r_p5);
                    r_state <= C_FLAG;
                end
                default: begin
                    o_res.cross_pos  <= (r_cross > 0);
                    o_res.cross_zero <= (r_cross == 0);
                    o_res.dl_zero    <= (r_dl == 0);
                    o_res.dr_zero    <= (r_dr == 0);
                    o_res.dl_lt_dr   <= (r_dl < r_dr);
                    o_res.dl_eq_dr   <= (r_dl == r_dr);
                    o_done           <= 1'b1;
                    r_state          <= C_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/convex_hull_graham_scan_top.sv
`timescale 1ns / 1ps
// Convex hull by Graham scan.
// Slave channel: one point per item, x in tdata[15:0], y in tdata[31:16];
// tlast marks the final point of a set and starts the hull. Points load at
// one per cycle into a single-port-write, registered-read point memory;
// points beyond MAX_POINTS are dropped.
// After the final point the block stops accepting items: a pivot search, a
// swap, an insertion sort about the pivot and a stack scan run out of the
// memory. Each orientation test goes through one shared multiplier unit.
// Master channel: one item per hull vertex, counterclockwise from the pivot,
// with tlast on the last one.
// A stalled receiver simply holds the vertex in the output register.
// Reset empties the point store; loading resumes after the last vertex.
module convex_hull_graham_scan_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // point_x[15:0], point_y[31:16]
    input  logic        i_s_axis_tlast,   // final_point
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // vertex_x, vertex_y, vertex_index, hull_size
    output logic        o_m_axis_tlast    // last_vertex
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int POINT_W_L = chgs_pkg::POINT_W;

    typedef enum logic [4:0] {
        S_LOAD, S_PV_RD, S_PV_CHK, S_SW_RD, S_SW_W0, S_SW_W1,
        S_SO_NXT, S_SO_KEY, S_SO_PRV, S_SO_CMP0, S_SO_CMP1, S_SO_WAIT,
        S_SC_INIT, S_SC_S1, S_SC_NXT, S_SC_CAND, S_SC_TST, S_SC_WAIT,
        S_SC_S2, S_SC_PUSH, S_FIN, S_FIN_W, S_EM_RD, S_EM_LD, S_EM_HOLD
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_cnt, r_n, r_i, r_j, r_top, r_k;
    logic [IW-1:0] r_best;
    chgs_pkg::t_point r_bpt, r_key, r_prev, r_s1, r_s2, r_cand, r_out;
    logic r_ovalid, r_olast;

    logic          w_in_acc, w_out_acc, w_store;
    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    chgs_pkg::t_point w_wdata, w_rd, w_in_pt;
    logic [POINT_W_L-1:0] w_rdata;
    logic          w_cmp_start, w_cmp_done;
    chgs_pkg::t_point w_co, w_ca, w_cb;
    chgs_pkg::t_cmp_res w_res;
    logic          w_less, w_before;
    logic [CW-1:0] w_nm1, w_jm1, w_topm3, w_kp1;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_ovalid && i_m_axis_tready;
    assign w_store   = (r_cnt < CW'(MAX_POINTS));
    assign w_rd      = chgs_pkg::t_point'(w_rdata);
    assign w_nm1     = r_n - 1'b1;
    assign w_jm1     = r_j - 1'b1;
    assign w_topm3   = r_top - CW'(3);
    assign w_kp1     = r_k + 1'b1;

    assign w_in_pt.x   = i_s_axis_tdata[15:0];
    assign w_in_pt.y   = i_s_axis_tdata[31:16];
    assign w_in_pt.tag = chgs_pkg::TAG_W'(r_cnt[IW-1:0]);

    // lower, then further left, wins the pivot
    assign w_less = (w_rd.y < r_bpt.y) || ((w_rd.y == r_bpt.y) && (w_rd.x < r_bpt.x));

    // key sorts strictly before prev about the pivot
    always_comb begin
        if (w_res.dl_zero || w_res.dr_zero) begin
            w_before = (w_res.dl_zero != w_res.dr_zero) ? w_res.dl_zero
                                                        : (r_key.tag < r_prev.tag);
        end else if (!w_res.cross_zero) begin
            w_before = w_res.cross_pos;
        end else if (!w_res.dl_eq_dr) begin
            w_before = w_res.dl_lt_dr;
        end else begin
            w_before = (r_key.tag < r_prev.tag);
        end
    end

    // memory port and geometry unit control
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_j[IW-1:0];
        w_wdata     = r_key;
        w_raddr     = r_i[IW-1:0];
        w_cmp_start = 1'b0;
        w_co        = r_bpt;
        w_ca        = r_key;
        w_cb        = r_prev;
        unique case (r_state)
            S_LOAD: begin
                w_we    = w_in_acc && w_store;
                w_waddr = r_cnt[IW-1:0];
                w_wdata = w_in_pt;
            end
            S_SW_RD: w_raddr = '0;
            S_SW_W0: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_bpt;
            end
            S_SW_W1: begin
                w_we    = 1'b1;
                w_waddr = r_best;
                w_wdata = r_key;
            end
            S_SO_PRV: begin
                w_raddr = w_jm1[IW-1:0];
                w_we    = (r_j <= CW'(1));
            end
            S_SO_CMP1: w_cmp_start = 1'b1;
            S_SO_WAIT: begin
                w_we    = w_cmp_done;
                w_wdata = w_before ? r_prev : r_key;
            end
            S_SC_INIT: w_raddr = IW'(1);
            S_SC_TST: begin
                w_cmp_start = (r_top > CW'(1));
                w_co        = r_s2;
                w_ca        = r_s1;
                w_cb        = r_cand;
            end
            S_SC_WAIT: w_raddr = w_topm3[IW-1:0];
            S_SC_PUSH: begin
                w_we    = 1'b1;
                w_waddr = r_top[IW-1:0];
                w_wdata = r_cand;
            end
            S_FIN: begin
                w_cmp_start = (r_top >= CW'(3));
                w_ca        = r_s1;
                w_cb        = r_s2;
            end
            S_EM_RD: w_raddr = r_k[IW-1:0];
            default: ;
        endcase
    end

    chgs_ram #(.WIDTH(POINT_W_L), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    chgs_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmp_start),
        .i_o     (w_co),
        .i_a     (w_ca),
        .i_b     (w_cb),
        .o_done  (w_cmp_done),
        .o_res   (w_res)
    );

    // sequencer: load, pivot, sort, scan, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tlast) begin
                            r_n     <= w_store ? r_cnt + 1'b1 : r_cnt;
                            r_cnt   <= '0;
                            r_i     <= '0;
                            r_best  <= '0;
                            r_state <= S_PV_RD;
                        end else if (w_store) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_PV_RD: r_state <= S_PV_CHK;
                S_PV_CHK: begin
                    if ((r_i == '0) || w_less) begin
                        r_bpt  <= w_rd;
                        r_best <= r_i[IW-1:0];
                    end
                    if (r_i == w_nm1) begin
                        r_state <= S_SW_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PV_RD;
                    end
                end
                S_SW_RD: r_state <= S_SW_W0;
                S_SW_W0: begin
                    r_key   <= w_rd;
                    r_state <= S_SW_W1;
                end
                S_SW_W1: begin
                    r_i     <= CW'(2);
                    r_state <= S_SO_NXT;
                end
                S_SO_NXT: begin
                    if (r_i >= r_n) begin
                        if (r_n <= CW'(2)) begin
                            r_top   <= r_n;
                            r_k     <= '0;
                            r_state <= S_EM_RD;
                        end else begin
                            r_state <= S_SC_INIT;
                        end
                    end else begin
                        r_state <= S_SO_KEY;
                    end
                end
                S_SO_KEY: begin
                    r_key   <= w_rd;
                    r_j     <= r_i;
                    r_state <= S_SO_PRV;
                end
                S_SO_PRV: begin
                    if (r_j > CW'(1)) begin
                        r_state <= S_SO_CMP0;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SO_NXT;
                    end
                end
                S_SO_CMP0: begin
                    r_prev  <= w_rd;
                    r_state <= S_SO_CMP1;
                end
                S_SO_CMP1: r_state <= S_SO_WAIT;
                S_SO_WAIT: begin
                    if (w_cmp_done) begin
                        if (w_before) begin
                            r_j     <= w_jm1;
                            r_state <= S_SO_PRV;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_SO_NXT;
                        end
                    end
                end
                S_SC_INIT: r_state <= S_SC_S1;
                S_SC_S1: begin
                    r_s1    <= w_rd;
                    r_s2    <= r_bpt;
                    r_top   <= CW'(2);
                    r_i     <= CW'(2);
                    r_state <= S_SC_NXT;
                end
                S_SC_NXT: r_state <= (r_i >= r_n) ? S_FIN : S_SC_CAND;
                S_SC_CAND: begin
                    r_cand  <= w_rd;
                    r_state <= S_SC_TST;
                end
                S_SC_TST: r_state <= (r_top > CW'(1)) ? S_SC_WAIT : S_SC_PUSH;
                S_SC_WAIT: begin
                    if (w_cmp_done) begin
                        if (w_res.cross_pos) begin
                            r_state <= S_SC_PUSH;
                        end else begin
                            // pop: the old second entry becomes the top
                            r_top   <= r_top - 1'b1;
                            r_s1    <= r_s2;
                            r_state <= (r_top > CW'(2)) ? S_SC_S2 : S_SC_TST;
                        end
                    end
                end
                S_SC_S2: begin
                    r_s2    <= w_rd;
                    r_state <= S_SC_TST;
                end
                S_SC_PUSH: begin
                    r_s2    <= r_s1;
                    r_s1    <= r_cand;
                    r_top   <= r_top + 1'b1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SC_NXT;
                end
                S_FIN: begin
                    r_k     <= '0;
                    r_state <= (r_top >= CW'(3)) ? S_FIN_W : S_EM_RD;
                end
                S_FIN_W: begin
                    if (w_cmp_done) begin
                        if (w_res.cross_zero) begin
                            r_top <= r_top - 1'b1;
                        end
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_RD: r_state <= S_EM_LD;
                S_EM_LD: begin
                    r_out    <= w_rd;
                    r_olast  <= (w_kp1 == r_top);
                    r_ovalid <= 1'b1;
                    r_state  <= S_EM_HOLD;
                end
                S_EM_HOLD: begin
                    if (w_out_acc) begin
                        r_ovalid <= 1'b0;
                        r_k      <= w_kp1;
                        r_state  <= r_olast ? S_LOAD : S_EM_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {3'b000, chgs_pkg::SIZE_W'(r_top), r_out.tag, r_out.y, r_out.x};

`ifndef SYNTH
    // no new point is taken while a vertex is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input accepted while output pending");

    // the stack never outgrows the points consumed
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_NXT) |-> (r_top <= r_i))
        else $error("hull stack exceeds scanned points");

    // a final point closes the set and clears the fill count
    a_close_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> (r_cnt == '0) && (r_n != '0))
        else $error("set not closed after final point");

    // geometry unit is only started while the sequencer waits on nothing else
    a_cmp_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmp_start |=> (r_state == S_SO_WAIT || r_state == S_SC_WAIT ||
                         r_state == S_FIN_W))
        else $error("comparison started outside a wait");
`endif

endmodule
